// ===== design/wisp_pkg.sv =====
// ----------------------------------------------------------------------------
// wisp_pkg: shared types and constants of the slot picker
// Widths, register indexes, reset values, FSM states and the control and
// running-maximum structs passed between the top level and the cells.
// ----------------------------------------------------------------------------
package wisp_pkg;

  localparam int NUM_APPS_DEF    = 7;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int APP_W    = 3;   // client index and apps_in_use width
  localparam int STEP_W   = 24;  // unsigned 8.16 reciprocal weight
  localparam int CREDIT_W = 40;  // signed 24.16 accumulator
  localparam int OUT_W    = 16;  // reported count and slot width
  localparam int CFG_W    = 24;  // widest register
  localparam int CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;  // 1.0
  localparam logic [APP_W-1:0]  APPS_RESET = 3'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_APPS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE   = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             clear;      // restart: zero credit and count
    logic             scan;       // scan step active
    logic [APP_W-1:0] scan_step;  // cell taking part in this scan cycle
    logic             update;     // charge the winner
    logic [APP_W-1:0] win;        // winning client
    logic [APP_W-1:0] apps;       // clients in use, already clamped
  } cell_ctl_t;

  // running maximum handed from cell to cell
  typedef struct packed {
    logic signed [CREDIT_W-1:0] credit;
    logic [APP_W-1:0]           idx;
  } run_t;

endpackage

// ===== design/wisp_in_if.sv =====
// ----------------------------------------------------------------------------
// wisp_in_if: draw request channel
// Valid/ready channel carrying the restart flag of one draw item.
// ----------------------------------------------------------------------------
interface wisp_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== design/wisp_out_if.sv =====
// ----------------------------------------------------------------------------
// wisp_out_if: slot result channel
// Valid/ready channel carrying the chosen client, its count and the slot.
// ----------------------------------------------------------------------------
interface wisp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  chosen_app;
  logic [15:0] chosen_count;
  logic [15:0] slot_number;

  modport source (output valid, output chosen_app, output chosen_count,
                  output slot_number, input ready);
  modport sink   (input valid, input chosen_app, input chosen_count,
                  input slot_number, output ready);
endinterface

// ===== design/wisp_cell.sv =====
// ----------------------------------------------------------------------------
// wisp_cell: one client of the interleave
// Holds the client's credit, slot count and step; takes part in the
// running-maximum scan and charges itself when it wins.
// ----------------------------------------------------------------------------
module wisp_cell #(
  parameter int IDX         = 0,
  parameter int COUNT_WIDTH = wisp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wisp_pkg::cell_ctl_t             ctl,
  input  logic                            step_we,
  input  logic [wisp_pkg::STEP_W-1:0]     step_data,
  input  wisp_pkg::run_t                  prev_run,
  input  logic [COUNT_WIDTH-1:0]          prev_given,
  output wisp_pkg::run_t                  run,
  output logic [COUNT_WIDTH-1:0]          run_given
);

  logic signed [wisp_pkg::CREDIT_W-1:0] credit_r, credit_nxt;
  logic [COUNT_WIDTH-1:0]               given_r, given_nxt;
  logic [wisp_pkg::STEP_W-1:0]          step_r;
  wisp_pkg::run_t                       run_r, run_nxt;
  logic [COUNT_WIDTH-1:0]               rgiven_r, rgiven_nxt;
  logic signed [wisp_pkg::CREDIT_W:0]   diff;
  logic                                 in_use;
  logic                                 take_own;

  localparam logic [wisp_pkg::APP_W-1:0] MY_IDX = wisp_pkg::APP_W'(IDX);

  assign in_use   = (MY_IDX < ctl.apps);
  // strict compare keeps ties with the lower index
  assign take_own = (IDX == 0) || (in_use && (credit_r > prev_run.credit));

  always_comb begin
    diff = {credit_r[wisp_pkg::CREDIT_W-1], credit_r}
         - $signed({{(wisp_pkg::CREDIT_W + 1 - wisp_pkg::STEP_W){1'b0}}, step_r});
    credit_nxt = credit_r;
    given_nxt  = given_r;
    if (ctl.clear) begin
      credit_nxt = '0;
      given_nxt  = '0;
    end else if (ctl.update && (ctl.win == MY_IDX)) begin
      // floor at the most negative credit
      if (diff[wisp_pkg::CREDIT_W] != diff[wisp_pkg::CREDIT_W-1]) begin
        credit_nxt = {1'b1, {(wisp_pkg::CREDIT_W-1){1'b0}}};
      end else begin
        credit_nxt = diff[wisp_pkg::CREDIT_W-1:0];
      end
      if (!(&given_r)) begin
        given_nxt = given_r + COUNT_WIDTH'(1);
      end
    end
  end

  always_comb begin
    run_nxt    = run_r;
    rgiven_nxt = rgiven_r;
    if (ctl.scan && (ctl.scan_step == MY_IDX)) begin
      if (take_own) begin
        run_nxt.credit = credit_r;
        run_nxt.idx    = MY_IDX;
        rgiven_nxt     = given_r;
      end else begin
        run_nxt    = prev_run;
        rgiven_nxt = prev_given;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      given_r  <= '0;
      step_r   <= wisp_pkg::STEP_RESET;
    end else begin
      credit_r <= credit_nxt;
      given_r  <= given_nxt;
      if (step_we) begin
        step_r <= step_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r    <= run_nxt;
    rgiven_r <= rgiven_nxt;
  end

  assign run       = run_r;
  assign run_given = rgiven_r;

endmodule

// ===== design/weighted_interleave_slot_picker.sv =====
// Flow: a new item is taken only in ST_IDLE, once the previous one is charged;
//   the running maximum walks the cell chain one cell per cycle, then
//   ST_UPDATE charges the winner and registers the result.
//   A result still waiting on the output holds the charge back.
// Reset (rst_n, synchronous, active low): credits, counts and slot number
//   zero, apps_in_use 1, every step 1.0, no result pending.
// ----------------------------------------------------------------------------
// weighted_interleave_slot_picker: weighted round-robin slot picker
// A row of client cells, each holding its own credit, count and step. A
// draw hands a running maximum down the row, one cell a cycle; the last
// cell names the winner, which is then charged its step.
// ----------------------------------------------------------------------------
module weighted_interleave_slot_picker #(
  parameter int NUM_APPS    = wisp_pkg::NUM_APPS_DEF,
  parameter int COUNT_WIDTH = wisp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wisp_in_if.sink                          in_ch,
  wisp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [wisp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wisp_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [wisp_pkg::APP_W-1:0] LAST_CELL = wisp_pkg::APP_W'(NUM_APPS - 1);
  localparam logic [wisp_pkg::APP_W-1:0] ROW_SIZE  = wisp_pkg::APP_W'(NUM_APPS);

  wisp_pkg::state_t              state_r, state_nxt;
  logic [wisp_pkg::APP_W-1:0]    step_cnt_r, step_cnt_nxt;
  logic [wisp_pkg::APP_W-1:0]    apps_r;
  logic [wisp_pkg::APP_W-1:0]    apps_eff;
  logic [COUNT_WIDTH-1:0]        pos_r, pos_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [wisp_pkg::APP_W-1:0]    out_app_r, out_app_nxt;
  logic [wisp_pkg::OUT_W-1:0]    out_count_r, out_count_nxt;
  logic [wisp_pkg::OUT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                          accept;
  logic                          out_free;
  logic                          restart_now;
  wisp_pkg::cell_ctl_t           ctl;

  wisp_pkg::run_t                run_w   [NUM_APPS+1];
  logic [COUNT_WIDTH-1:0]        given_w [NUM_APPS+1];
  logic [COUNT_WIDTH-1:0]        win_given_inc;

  // clamp a count to the 16-bit report range
  function automatic logic [wisp_pkg::OUT_W-1:0] out16(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'd65535) begin
      return 16'hFFFF;
    end
    return wide[wisp_pkg::OUT_W-1:0];
  endfunction

  // clients in use: zero reads as one, above the row as the whole row
  always_comb begin
    if (apps_r == '0) begin
      apps_eff = wisp_pkg::APP_W'(1);
    end else if (apps_r > ROW_SIZE) begin
      apps_eff = ROW_SIZE;
    end else begin
      apps_eff = apps_r;
    end
  end

  assign accept      = in_ch.valid && in_ch.ready;
  assign restart_now = accept && in_ch.restart;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == wisp_pkg::ST_IDLE);

  // winner's count after this draw, saturating at the counter ceiling
  assign win_given_inc = (&given_w[NUM_APPS]) ? given_w[NUM_APPS]
                                              : given_w[NUM_APPS] + COUNT_WIDTH'(1);

  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_app_nxt   = out_app_r;
    out_count_nxt = out_count_r;
    out_slot_nxt  = out_slot_r;

    ctl.clear     = restart_now;
    ctl.scan      = 1'b0;
    ctl.scan_step = step_cnt_r;
    ctl.update    = 1'b0;
    ctl.win       = run_w[NUM_APPS].idx;
    ctl.apps      = apps_eff;

    // drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      wisp_pkg::ST_IDLE: begin
        if (accept) begin
          step_cnt_nxt = '0;
          state_nxt    = wisp_pkg::ST_SCAN;
          if (in_ch.restart) begin
            pos_nxt = '0;
          end
        end
      end
      wisp_pkg::ST_SCAN: begin
        // advance the running maximum one cell
        ctl.scan = 1'b1;
        if (step_cnt_r == LAST_CELL) begin
          state_nxt = wisp_pkg::ST_UPDATE;
        end else begin
          step_cnt_nxt = step_cnt_r + wisp_pkg::APP_W'(1);
        end
      end
      wisp_pkg::ST_UPDATE: begin
        // hold until the output register is free, then charge and report
        if (out_free) begin
          ctl.update    = 1'b1;
          out_valid_nxt = 1'b1;
          out_app_nxt   = run_w[NUM_APPS].idx;
          out_count_nxt = out16(win_given_inc);
          out_slot_nxt  = out16(pos_r);
          if (!(&pos_r)) begin
            pos_nxt = pos_r + COUNT_WIDTH'(1);
          end
          state_nxt = wisp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wisp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wisp_pkg::ST_IDLE;
      step_cnt_r  <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      apps_r      <= wisp_pkg::APPS_RESET;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == wisp_pkg::REG_APPS_IN_USE)) begin
        apps_r <= cfg_data[wisp_pkg::APP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_app_r   <= out_app_nxt;
    out_count_r <= out_count_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.chosen_app   = out_app_r;
  assign out_ch.chosen_count = out_count_r;
  assign out_ch.slot_number  = out_slot_r;

  // head of the chain: cell 0 always takes its own credit
  assign run_w[0]   = '0;
  assign given_w[0] = '0;

  for (genvar g = 0; g < NUM_APPS; g++) begin : g_cell
    logic step_we;
    assign step_we = cfg_we
                  && (cfg_index == (wisp_pkg::REG_STEP_BASE + wisp_pkg::CFG_IDX_W'(g)));

    wisp_cell #(
      .IDX         (g),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .step_we    (step_we),
      .step_data  (cfg_data[wisp_pkg::STEP_W-1:0]),
      .prev_run   (run_w[g]),
      .prev_given (given_w[g]),
      .run        (run_w[g+1]),
      .run_given  (given_w[g+1])
    );
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the weighted interleave slot picker
// Drives draw items with random gaps and restarts, stalls the result side
// at random and checks every slot against an in-bench copy of the credit,
// count and slot state. Covers several weight settings, clamped client
// counts, zero steps, and a run with no gaps on either side.
// ----------------------------------------------------------------------------
module tb;

  localparam int     N_CLIENTS     = wisp_pkg::NUM_APPS_DEF;
  localparam longint CREDIT_FLOOR  = -(longint'(1) <<< (wisp_pkg::CREDIT_W - 1));
  localparam int     CYCLE_LIMIT   = 3_000_000;
  localparam int     LONG_DRAWS    = 200;
  localparam int     RANDOM_PHASES = 10;
  localparam int     PHASE_ITEMS   = 150;
  localparam int     IDLE_PCT      = 22;
  localparam int     RESTART_PCT   = 5;

  typedef struct packed {
    logic [wisp_pkg::APP_W-1:0] app;
    logic [wisp_pkg::OUT_W-1:0] count;
    logic [wisp_pkg::OUT_W-1:0] slot;
  } slot_t;

  // Mirror of the picker: register copies, per-client credit and count, the
  // slot position, and the slots still owed by the block.
  class slot_ledger;
    logic [wisp_pkg::APP_W-1:0]           apps;
    logic [wisp_pkg::STEP_W-1:0]          steps [N_CLIENTS];
    logic signed [wisp_pkg::CREDIT_W-1:0] credit [N_CLIENTS];
    logic [wisp_pkg::OUT_W-1:0]           given [N_CLIENTS];
    logic [wisp_pkg::OUT_W-1:0]           position;
    slot_t                                pending_slots [$];
    int                                   errors;

    function new();
      apps = wisp_pkg::APPS_RESET;
      foreach (steps[k]) steps[k] = wisp_pkg::STEP_RESET;
      foreach (credit[k]) begin
        credit[k] = '0;
        given[k]  = '0;
      end
      position = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [wisp_pkg::CFG_IDX_W-1:0] idx,
                            logic [wisp_pkg::CFG_W-1:0] data);
      if (idx == wisp_pkg::REG_APPS_IN_USE) begin
        apps = data[wisp_pkg::APP_W-1:0];
      end else begin
        steps[idx - wisp_pkg::REG_STEP_BASE] = data[wisp_pkg::STEP_W-1:0];
      end
    endfunction

    // Work out the slot that one accepted draw item earns and queue it.
    function void note_draw(logic restart);
      int     n;
      int     best;
      longint nxt;
      slot_t  s;
      if (restart) begin
        foreach (credit[k]) begin
          credit[k] = '0;
          given[k]  = '0;
        end
        position = '0;
      end
      // clamp the client count: none means one, the top is the row size
      n = int'(apps);
      if (n == 0) n = 1;
      if (n > N_CLIENTS) n = N_CLIENTS;
      // largest credit wins, lowest index on a tie
      best = 0;
      for (int j = 1; j < n; j++) begin
        if (credit[j] > credit[best]) best = j;
      end
      nxt = longint'(credit[best]) - longint'(steps[best]);
      if (nxt < CREDIT_FLOOR) nxt = CREDIT_FLOOR;
      credit[best] = wisp_pkg::CREDIT_W'(nxt);
      if (given[best] != '1) given[best] = given[best] + 1'b1;
      s.app   = wisp_pkg::APP_W'(best);
      s.count = given[best];
      s.slot  = position;
      if (position != '1) position = position + 1'b1;
      pending_slots = {pending_slots, s};
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_slot(slot_t got);
      slot_t want;
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("slot %0d for client %0d with no draw pending",
                                  got.slot, got.app));
      end else begin
        want = pending_slots.pop_front();
        if (got.app !== want.app)
          report_mismatch($sformatf("slot %0d: chosen_app %0d, expected %0d",
                                    want.slot, got.app, want.app));
        if (got.count !== want.count)
          report_mismatch($sformatf("slot %0d: chosen_count %0d, expected %0d",
                                    want.slot, got.count, want.count));
        if (got.slot !== want.slot)
          report_mismatch($sformatf("slot_number %0d, expected %0d",
                                    got.slot, want.slot));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [wisp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wisp_pkg::CFG_W-1:0]     cfg_data;

  wisp_in_if  in_ch ();
  wisp_out_if out_ch ();

  weighted_interleave_slot_picker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  slot_ledger ledger;

  // Gap controls: idle_on belongs to the sending process alone; stall_on is
  // read by the receiver at each edge, so change it with nonblocking writes.
  bit          idle_on  = 1'b1;
  bit          stall_on = 1'b1;
  int unsigned cycles   = 0;

  // Setting to load at the next idle point.
  logic [wisp_pkg::CFG_W-1:0]  set_apps_word;
  logic [wisp_pkg::STEP_W-1:0] set_steps [N_CLIENTS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result side in about one cycle in five while stalling is on.
  always @(posedge clk) begin
    out_ch.ready <= !stall_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Note every accepted draw, then check every accepted slot. A slot never
  // comes back on the edge its own draw is taken, so the order is safe.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) ledger.note_draw(in_ch.restart);
    if (rst_n && out_ch.valid && out_ch.ready)
      ledger.check_slot({out_ch.chosen_app, out_ch.chosen_count, out_ch.slot_number});
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one draw item, after a random gap while idling is on, and hold it
  // until the block takes it. Valid stays high into the next item when no
  // gap follows.
  task send_draw(logic restart);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for every owed slot; the first edge lets the
  // monitor note the last draw before the queue is looked at.
  task wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_slots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register from the pending setting; only call when idle.
  task apply_setting();
    cfg_we    <= 1'b1;
    cfg_index <= wisp_pkg::REG_APPS_IN_USE;
    cfg_data  <= set_apps_word;
    @(posedge clk);
    ledger.write_reg(wisp_pkg::REG_APPS_IN_USE, set_apps_word);
    for (int k = 0; k < N_CLIENTS; k++) begin
      cfg_index <= wisp_pkg::REG_STEP_BASE + wisp_pkg::CFG_IDX_W'(k);
      cfg_data  <= set_steps[k];
      @(posedge clk);
      ledger.write_reg(wisp_pkg::REG_STEP_BASE + wisp_pkg::CFG_IDX_W'(k), set_steps[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // Steps lean towards moderate weights so the interleave mixes clients,
  // with zero, full scale and unrestricted values mixed in.
  function logic [wisp_pkg::STEP_W-1:0] random_step();
    case ($urandom_range(9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return wisp_pkg::STEP_W'($urandom_range(24'h040000, 24'h004000));
      default:    return wisp_pkg::STEP_W'($urandom);
    endcase
  endfunction

  initial begin
    ledger = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= wisp_pkg::REG_APPS_IN_USE;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: one client at weight 1.0, restart in the middle.
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);

    // All seven clients, mixed weights; client 3 has a zero step and
    // keeps winning once the others have fallen below it.
    wait_drain();
    set_apps_word = wisp_pkg::CFG_W'(7);
    set_steps = '{24'h010000, 24'h008000, 24'hFFFFFF, 24'h000000,
                  24'h020000, 24'h000001, 24'h018000};
    apply_setting();
    send_draw(1'b1);
    repeat (6) send_draw(1'b0);

    // Zero clients in use counts as one; junk in the upper data bits.
    wait_drain();
    set_apps_word = 24'hABCDE8;
    apply_setting();
    repeat (3) send_draw(1'b0);

    // Drop to three clients: the rest keep their credit but sit out.
    wait_drain();
    set_apps_word = wisp_pkg::CFG_W'(3);
    apply_setting();
    repeat (4) send_draw(1'b0);

    // Back to all seven at full-scale steps, dropped clients rejoin.
    wait_drain();
    set_apps_word = wisp_pkg::CFG_W'(7);
    foreach (set_steps[k]) set_steps[k] = '1;
    apply_setting();
    repeat (4) send_draw(1'b0);
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);

    // Long run with no gaps on either side: one client at full-scale step
    // takes every slot back to back.
    wait_drain();
    idle_on  = 1'b0;
    stall_on <= 1'b0;
    set_apps_word = wisp_pkg::CFG_W'(1);
    foreach (set_steps[k]) set_steps[k] = wisp_pkg::STEP_RESET;
    set_steps[0] = '1;
    apply_setting();
    send_draw(1'b1);
    repeat (LONG_DRAWS) send_draw(1'b0);

    // Random phases, each with a fresh setting and occasional restarts.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drain();
      case (ph)
        0: begin
          set_apps_word = wisp_pkg::CFG_W'(7);
          foreach (set_steps[k]) set_steps[k] = '1;
        end
        1: begin
          // zero steps: credits stand still, so the leading client (lowest index on a tie) takes every slot
          set_apps_word = wisp_pkg::CFG_W'(7);
          foreach (set_steps[k]) set_steps[k] = '0;
        end
        default: begin
          set_apps_word = wisp_pkg::CFG_W'($urandom);
          set_apps_word[wisp_pkg::APP_W-1:0] = wisp_pkg::APP_W'($urandom_range(7));
          foreach (set_steps[k]) set_steps[k] = random_step();
        end
      endcase
      apply_setting();
      // one phase runs flat out, the rest idle and stall at random
      idle_on  = (ph != 5);
      stall_on <= (ph != 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender once until every owed slot is back
        if (ph == 3 && i == PHASE_ITEMS / 2) wait_drain();
        send_draw($urandom_range(99) < RESTART_PCT);
      end
    end

    wait_drain();
    repeat (12) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
